/* hw/rtl/aho_pkg.sv */
// Shared constants, codes and request/result types of the Aho-Corasick matcher.
package aho_pkg;

  // Automaton sizing
  localparam int NODES       = 256;
  localparam int CHAR_BITS   = 8;
  localparam int PATTERNS    = 256;
  localparam int MAX_DEPTH   = 32;
  localparam int MAX_RESULTS = 32;

  localparam int NODE_W  = $clog2(NODES);
  localparam int NCNT_W  = $clog2(NODES + 1);
  localparam int PAT_W   = $clog2(PATTERNS);
  localparam int PCNT_W  = $clog2(PATTERNS + 1);
  localparam int LEN_W   = $clog2(MAX_DEPTH + 1);
  localparam int PBUF_N  = MAX_DEPTH + 1;
  localparam int PBUF_W  = $clog2(PBUF_N);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int CHILD_N = NODES << CHAR_BITS;

  // Action codes of a request
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_ROOT   = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_MATCH    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
    logic       pattern_end;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] match_id;
    logic [5:0] match_length;
    logic [7:0] current_node;
    logic       run_last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic push_reject;
    logic push_misc;
    logic ins_commit;
    logic ps_walk;
    logic walk_step;
    logic walk_u;
    logic k_init;
    logic k_read;
    logic k_eval;
    logic push_match;
    logic push_nomatch;
    logic flush;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       clr_done;
    logic [1:0] action;
    logic       ins_reject;
    logic       walk_zero;
    logic       jneg;
    logic       k_fin;
    logic       term;
    logic       u_zero;
    logic       cnt_last;
    logic       cnt_zero;
  } stat_t;

endpackage

/* hw/rtl/aho_dp.sv */
// Datapath of the matcher: trie memories, path buffer, walk registers, result staging.
module aho_dp import aho_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  // Memories
  logic [NODE_W-1:0]           child_mem [CHILD_N];
  logic [NODE_W+CHAR_BITS-1:0] ps_mem    [NODES];
  logic [PAT_W-1:0]            pat_mem   [NODES];
  logic [LEN_W-1:0]            len_mem   [PATTERNS];
  logic [CHAR_BITS-1:0]        pbuf      [PBUF_N];

  // Control state
  logic [NCNT_W-1:0] node_count_q, node_count_d;
  logic [PCNT_W-1:0] pattern_count_q, pattern_count_d;
  logic [NODE_W-1:0] ins_cur_q, ins_cur_d;
  logic [LEN_W-1:0]  ins_depth_q, ins_depth_d;
  logic [NODE_W-1:0] search_q, search_d;
  logic [NODES-1:0]  term_q, term_d;
  logic              pend_v_q, pend_v_d;
  logic [RES_W-1:0]  rescnt_q, rescnt_d;
  logic              res_valid_q, res_valid_d;
  logic [NODE_W+CHAR_BITS-1:0] clr_addr_q, clr_addr_d;

  // Payload
  logic [NODE_W-1:0]           lk_node_q;
  logic [CHAR_BITS-1:0]        lk_sym_q;
  logic                        end_q;
  logic [NODE_W-1:0]           child_rd_q;
  logic [NODE_W+CHAR_BITS-1:0] ps_rd_q;
  logic [PAT_W-1:0]            pat_rd_q;
  logic [LEN_W-1:0]            len_rd_q;
  logic [NODE_W-1:0]           walk_q;
  logic [PBUF_W-1:0]           plen_q;
  logic                        phase_q;
  logic [PBUF_W-1:0]           jstart_q, j_q;
  logic [NODE_W-1:0]           wnode_q, u_q;
  res_t                        pend_q, res_q;

  logic [CHAR_BITS-1:0]  sym;
  logic [NODE_W-1:0]     ps_addr;
  logic [NODE_W-1:0]     ps_parent;
  logic [CHAR_BITS-1:0]  ps_sym;
  logic                  lk_valid;
  logic                  ins_drop;
  logic [NODE_W-1:0]     new_node;
  logic [PAT_W-1:0]      pat_idx;
  logic [PBUF_W-1:0]     jstart;
  logic                  jneg;
  logic                  k_fin;
  logic [NODE_W-1:0]     k_res;
  logic                  is_search;
  logic                  do_push;
  res_t                  nres;

  assign sym       = req_i.symbol[CHAR_BITS-1:0];
  assign is_search = (req_i.action == ACT_SEARCH);
  assign ps_addr   = cmd_i.ps_walk ? walk_q : child_rd_q;
  assign ps_parent = ps_rd_q[NODE_W+CHAR_BITS-1:CHAR_BITS];
  assign ps_sym    = ps_rd_q[CHAR_BITS-1:0];
  assign pat_idx   = pattern_count_q[PAT_W-1:0];

  // Child entry is genuine only if its node points back to this parent and symbol
  assign lk_valid = (child_rd_q != '0) &&
                    ({1'b0, child_rd_q} < node_count_q) &&
                    (ps_rd_q == {lk_node_q, lk_sym_q});
  assign ins_drop = !lk_valid && (node_count_q >= NCNT_W'(NODES));
  assign new_node = lk_valid ? child_rd_q : node_count_q[NODE_W-1:0];

  // Suffix scan bounds
  assign jneg   = (plen_q <= {{(PBUF_W-1){1'b0}}, phase_q});
  assign jstart = plen_q - PBUF_W'(1) - {{(PBUF_W-1){1'b0}}, phase_q};
  assign k_fin  = lk_valid ? (j_q == '0) : (jstart_q == '0);
  assign k_res  = lk_valid ? child_rd_q : '0;

  // Status to controller
  always_comb begin
    stat_o.clr_done   = (clr_addr_q == '1);
    stat_o.action     = req_i.action;
    stat_o.ins_reject = (ins_depth_q >= LEN_W'(MAX_DEPTH)) ||
                        (req_i.pattern_end && (pattern_count_q >= PCNT_W'(PATTERNS)));
    stat_o.walk_zero  = (walk_q == '0);
    stat_o.jneg       = jneg;
    stat_o.k_fin      = k_fin;
    stat_o.term       = term_q[u_q];
    stat_o.u_zero     = (u_q == '0);
    stat_o.cnt_last   = (rescnt_q == RES_W'(MAX_RESULTS - 1));
    stat_o.cnt_zero   = (rescnt_q == '0);
  end

  // New result selection
  always_comb begin
    nres = '0;
    nres.status = ST_ACCEPTED;
    do_push = 1'b1;
    if (cmd_i.push_reject) begin
      nres.status       = ST_FULL;
      nres.current_node = 8'(ins_cur_q);
    end else if (cmd_i.push_misc) begin
      nres.current_node = (req_i.action == ACT_ROOT) ? 8'd0 : 8'(search_q);
    end else if (cmd_i.ins_commit) begin
      nres.status       = ins_drop ? ST_FULL : ST_ACCEPTED;
      nres.current_node = ins_drop ? 8'(lk_node_q) : 8'(new_node);
    end else if (cmd_i.push_match) begin
      nres.status       = ST_MATCH;
      nres.match_id     = 8'(pat_rd_q);
      nres.match_length = 6'(len_rd_q);
      nres.current_node = 8'(search_q);
    end else if (cmd_i.push_nomatch) begin
      nres.status       = ST_NO_MATCH;
      nres.current_node = 8'(search_q);
    end else begin
      do_push = 1'b0;
    end
  end

  // Next control state
  always_comb begin
    node_count_d    = node_count_q;
    pattern_count_d = pattern_count_q;
    ins_cur_d       = ins_cur_q;
    ins_depth_d     = ins_depth_q;
    search_d        = search_q;
    term_d          = term_q;
    pend_v_d        = pend_v_q;
    rescnt_d        = rescnt_q;
    res_valid_d     = 1'b0;
    clr_addr_d      = clr_addr_q;
    if (cmd_i.clear) begin
      clr_addr_d = clr_addr_q + 1'b1;
    end
    if (cmd_i.load && (req_i.action == ACT_ROOT)) begin
      search_d = '0;
    end
    if (cmd_i.ins_commit && !ins_drop) begin
      if (!lk_valid) begin
        node_count_d = node_count_q + NCNT_W'(1);
      end
      if (end_q) begin
        term_d[new_node] = 1'b1;
        pattern_count_d  = pattern_count_q + PCNT_W'(1);
        ins_cur_d        = '0;
        ins_depth_d      = '0;
      end else begin
        ins_cur_d   = new_node;
        ins_depth_d = ins_depth_q + LEN_W'(1);
      end
    end
    if (cmd_i.k_eval && k_fin && !phase_q) begin
      search_d = k_res;
    end
    if (do_push) begin
      pend_v_d    = 1'b1;
      rescnt_d    = rescnt_q + RES_W'(1);
      res_valid_d = pend_v_q;
    end
    if (cmd_i.flush) begin
      pend_v_d    = 1'b0;
      rescnt_d    = '0;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q    <= NCNT_W'(1);
      pattern_count_q <= '0;
      ins_cur_q       <= '0;
      ins_depth_q     <= '0;
      search_q        <= '0;
      term_q          <= '0;
      pend_v_q        <= 1'b0;
      rescnt_q        <= '0;
      res_valid_q     <= 1'b0;
      clr_addr_q      <= '0;
    end else begin
      node_count_q    <= node_count_d;
      pattern_count_q <= pattern_count_d;
      ins_cur_q       <= ins_cur_d;
      ins_depth_q     <= ins_depth_d;
      search_q        <= search_d;
      term_q          <= term_d;
      pend_v_q        <= pend_v_d;
      rescnt_q        <= rescnt_d;
      res_valid_q     <= res_valid_d;
      clr_addr_q      <= clr_addr_d;
    end
  end

  // Result staging: one held back so the last of a run can be marked
  always_ff @(posedge clk_i) begin
    if (cmd_i.flush) begin
      res_q <= {pend_q[$bits(res_t)-1:1], 1'b1};
    end else if (do_push) begin
      pend_q <= nres;
      res_q  <= {pend_q[$bits(res_t)-1:1], 1'b0};
    end
  end

  // Walk, scan and lookup registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      end_q     <= req_i.pattern_end;
      lk_node_q <= ins_cur_q;
      lk_sym_q  <= sym;
      if (is_search) begin
        walk_q  <= search_q;
        plen_q  <= PBUF_W'(1);
        phase_q <= 1'b0;
      end
    end
    if (cmd_i.walk_u) begin
      walk_q  <= u_q;
      plen_q  <= '0;
      phase_q <= 1'b1;
    end
    if (cmd_i.walk_step) begin
      walk_q <= ps_parent;
      plen_q <= plen_q + PBUF_W'(1);
    end
    if (cmd_i.k_init) begin
      if (jneg) begin
        u_q <= '0;
      end else begin
        jstart_q <= jstart;
        j_q      <= jstart;
        wnode_q  <= '0;
      end
    end
    if (cmd_i.k_read) begin
      lk_node_q <= wnode_q;
      lk_sym_q  <= pbuf[j_q];
    end
    if (cmd_i.k_eval) begin
      if (k_fin) begin
        u_q <= k_res;
      end else if (lk_valid) begin
        wnode_q <= child_rd_q;
        j_q     <= j_q - PBUF_W'(1);
      end else begin
        jstart_q <= jstart_q - PBUF_W'(1);
        j_q      <= jstart_q - PBUF_W'(1);
        wnode_q  <= '0;
      end
    end
  end

  // Path buffer, deepest symbol first
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && is_search) begin
      pbuf[0] <= sym;
    end else if (cmd_i.walk_step) begin
      pbuf[plen_q] <= ps_sym;
    end
  end

  // Child table, zeroed one entry per cycle after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      child_mem[clr_addr_q] <= '0;
    end else if (cmd_i.ins_commit && !ins_drop && !lk_valid) begin
      child_mem[{lk_node_q, lk_sym_q}] <= new_node;
    end
    child_rd_q <= child_mem[{lk_node_q, lk_sym_q}];
  end

  // Parent and symbol of each node
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit && !ins_drop && !lk_valid) begin
      ps_mem[new_node] <= {lk_node_q, lk_sym_q};
    end
    ps_rd_q <= ps_mem[ps_addr];
  end

  // Pattern number per terminal node
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit && !ins_drop && end_q) begin
      pat_mem[new_node] <= pat_idx;
    end
    pat_rd_q <= pat_mem[u_q];
  end

  // Pattern lengths
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit && !ins_drop && end_q) begin
      len_mem[pat_idx] <= ins_depth_q + LEN_W'(1);
    end
    len_rd_q <= len_mem[pat_rd_q];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/aho_ctrl.sv */
// Controller state machine of the matcher: sequences inserts, path walks and suffix scans.
module aho_ctrl import aho_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_I_LA  = 17'h00002,
    S_I_LB  = 17'h00004,
    S_I_LC  = 17'h00008,
    S_PWA   = 17'h00010,
    S_PWB   = 17'h00020,
    S_KS    = 17'h00040,
    S_KR    = 17'h00080,
    S_LA    = 17'h00100,
    S_LB    = 17'h00200,
    S_LC    = 17'h00400,
    S_OUT   = 17'h00800,
    S_OP1   = 17'h01000,
    S_OP2   = 17'h02000,
    S_END   = 17'h04000,
    S_FLUSH = 17'h08000,
    S_CLEAR = 17'h10000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      // Zero the child table after reset
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (stat_i.action)
            ACT_INSERT: begin
              if (stat_i.ins_reject) begin
                cmd_o.push_reject = 1'b1;
                state_d = S_FLUSH;
              end else begin
                state_d = S_I_LA;
              end
            end
            ACT_SEARCH: state_d = S_PWA;
            default: begin
              cmd_o.push_misc = 1'b1;
              state_d = S_FLUSH;
            end
          endcase
        end
      end
      S_I_LA: state_d = S_I_LB;
      S_I_LB: state_d = S_I_LC;
      S_I_LC: begin
        cmd_o.ins_commit = 1'b1;
        state_d = S_FLUSH;
      end
      // Collect the path of a node up to the root
      S_PWA: begin
        if (stat_i.walk_zero) begin
          state_d = S_KS;
        end else begin
          cmd_o.ps_walk = 1'b1;
          state_d = S_PWB;
        end
      end
      S_PWB: begin
        cmd_o.walk_step = 1'b1;
        state_d = S_PWA;
      end
      // Longest suffix present in the trie
      S_KS: begin
        cmd_o.k_init = 1'b1;
        state_d = stat_i.jneg ? S_OUT : S_KR;
      end
      S_KR: begin
        cmd_o.k_read = 1'b1;
        state_d = S_LA;
      end
      S_LA: state_d = S_LB;
      S_LB: state_d = S_LC;
      S_LC: begin
        cmd_o.k_eval = 1'b1;
        state_d = stat_i.k_fin ? S_OUT : S_KR;
      end
      // Report along the output chain
      S_OUT: begin
        if (stat_i.term) begin
          state_d = S_OP1;
        end else if (stat_i.u_zero) begin
          state_d = S_END;
        end else begin
          cmd_o.walk_u = 1'b1;
          state_d = S_PWA;
        end
      end
      S_OP1: state_d = S_OP2;
      S_OP2: begin
        cmd_o.push_match = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = S_FLUSH;
        end else if (stat_i.u_zero) begin
          state_d = S_END;
        end else begin
          cmd_o.walk_u = 1'b1;
          state_d = S_PWA;
        end
      end
      S_END: begin
        cmd_o.push_nomatch = stat_i.cnt_zero;
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/aho_corasick_matcher.sv */
// Top level of the Aho-Corasick multi-pattern matcher: controller plus datapath.
// Insert: a lookup through states I_LA, I_LB and I_LC, then commit and flush to its result;
// a refused insert, a return to root or an unused action goes straight to the flush. Search:
// states PWA and PWB per node on each parent walk, KR, LA, LB, LC per suffix-scan lookup.
// One request at a time; results cannot be stalled; next start at the last result's edge.
// Reset clears counters, cursors and flags; a pass in state CLEAR then zeroes the child table.
module aho_corasick_matcher import aho_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  cmd_t  cmd;
  stat_t stat;

  aho_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  aho_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a request in progress");

  // Nothing follows the last result of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.run_last) |=> !res_valid_o)
    else $error("result after last of run");

  // An accepted request always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the Aho-Corasick matcher: trie predictor, driver and monitor.
`timescale 1ns / 1ps

module tb;
  import aho_pkg::*;

  // Action code the block treats as a no-op
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic res_valid_o;
  res_t res_o;

  aho_corasick_matcher dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Trie mirror: child entries hold node+1, zero means no child
  int unsigned kid [NODES << CHAR_BITS];
  int unsigned node_up [NODES];
  int unsigned node_sym [NODES];
  int unsigned node_pat [NODES];
  bit          node_term [NODES];
  int unsigned pat_len [PATTERNS];
  int unsigned n_nodes = 1, n_pats = 0, ins_node = 0, ins_depth = 0, srch_node = 0;
  int unsigned pathbuf [MAX_DEPTH + 2];

  req_t pending_reqs [$];
  res_t expected_results [$];
  int   n_taken = 0;
  int   n_errors = 0;

  function automatic res_t make_res(status_e st, int unsigned id, int unsigned len,
                                    int unsigned node);
    res_t r;
    r.status = st;
    r.match_id = id[7:0];
    r.match_length = len[5:0];
    r.current_node = node[7:0];
    r.run_last = 1'b0;
    return r;
  endfunction

  // Symbols along the root-to-v path into pathbuf; returns length
  function automatic int unsigned load_path(int unsigned v);
    int unsigned tmp [MAX_DEPTH + 2];
    int unsigned d;
    d = 0;
    while (v != 0 && d < MAX_DEPTH) begin
      tmp[d] = node_sym[v];
      d++;
      v = node_up[v];
    end
    for (int i = 0; i < d; i++) pathbuf[i] = tmp[d - 1 - i];
    return d;
  endfunction

  // Deepest trie node spelling a suffix of pathbuf starting at or after first
  function automatic int unsigned deepest_suffix(int unsigned len, int unsigned first);
    int unsigned node, e;
    bit ok;
    for (int unsigned k = first; k < len; k++) begin
      node = 0;
      ok = 1'b1;
      for (int unsigned i = k; i < len; i++) begin
        e = kid[node * 256 + pathbuf[i]];
        if (e == 0) begin
          ok = 1'b0;
          break;
        end
        node = e - 1;
      end
      if (ok) return node;
    end
    return 0;
  endfunction

  // Advance the automaton mirror by one request and queue its results
  function automatic void predict_results(req_t rq);
    res_t outs [$];
    int unsigned sym, e, node, len, u;
    sym = rq.symbol;
    if (rq.action == ACT_INSERT) begin
      e = kid[ins_node * 256 + sym];
      if (ins_depth >= MAX_DEPTH || (rq.pattern_end && n_pats >= PATTERNS) ||
          (e == 0 && n_nodes >= NODES)) begin
        outs = {outs, make_res(ST_FULL, 0, 0, ins_node)};
      end else begin
        if (e == 0) begin
          node = n_nodes;
          n_nodes++;
          node_up[node] = ins_node;
          node_sym[node] = sym;
          kid[ins_node * 256 + sym] = node + 1;
        end else begin
          node = e - 1;
        end
        ins_node = node;
        ins_depth++;
        if (rq.pattern_end) begin
          node_term[node] = 1'b1;
          node_pat[node] = n_pats;
          pat_len[n_pats] = ins_depth;
          n_pats++;
          ins_node = 0;
          ins_depth = 0;
        end
        outs = {outs, make_res(ST_ACCEPTED, 0, 0, node)};
      end
    end else if (rq.action == ACT_SEARCH) begin
      len = load_path(srch_node);
      pathbuf[len] = sym;
      srch_node = deepest_suffix(len + 1, 0);
      u = srch_node;
      for (int g = 0; g <= MAX_DEPTH && outs.size() < MAX_RESULTS; g++) begin
        if (node_term[u])
          outs = {outs, make_res(ST_MATCH, node_pat[u], pat_len[node_pat[u]], srch_node)};
        if (u == 0) break;
        len = load_path(u);
        u = deepest_suffix(len, 1);
      end
      if (outs.size() == 0) outs = {outs, make_res(ST_NO_MATCH, 0, 0, srch_node)};
    end else begin
      if (rq.action == ACT_ROOT) srch_node = 0;
      outs = {outs, make_res(ST_ACCEPTED, 0, 0, srch_node)};
    end
    outs[outs.size() - 1].run_last = 1'b1;
    expected_results = {expected_results, outs};
  endfunction

  // Driver: present next request at the falling edge, idling at random except while n_taken is in [150, 260)
  always @(negedge clk_i) begin
    if (rst_ni && pending_reqs.size() != 0 &&
        ((n_taken >= 150 && n_taken < 260) || $urandom_range(0, 99) >= 33)) begin
      start <= 1'b1;
      req_i <= pending_reqs[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results first, then record an accepted request
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %p", res_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (res_o !== exp_r) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p actual %p", exp_r, res_o);
          end
        end
      end
      if (start && !busy && pending_reqs.size() != 0) begin
        predict_results(pending_reqs.pop_front());
        n_taken++;
      end
    end
  end

  task automatic add_req(logic [1:0] act, logic [7:0] sym, logic fin);
    req_t rq;
    rq.action = act;
    rq.symbol = sym;
    rq.pattern_end = fin;
    pending_reqs = {pending_reqs, rq};
  endtask

  task automatic add_pattern(string s);
    for (int i = 0; i < s.len(); i++) add_req(ACT_INSERT, s[i], i == s.len() - 1);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_req(ACT_SEARCH, s[i], 1'b0);
  endtask

  // Letters from a small alphabet so that texts hit patterns, now and then any byte
  function automatic logic [7:0] pick_sym();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'(8'h61 + $urandom_range(0, 3));
  endfunction

  initial begin
    int n, r;
    // Directed: classic pattern set, duplicate, extreme bytes, unused action
    add_pattern("he");
    add_pattern("she");
    add_pattern("his");
    add_text("ushers");
    add_req(ACT_ROOT, 8'h00, 1'b0);
    add_req(ACT_SPARE, 8'hFF, 1'b1);
    add_req(ACT_INSERT, 8'h00, 1'b1);
    add_req(ACT_INSERT, 8'hFF, 1'b1);
    add_pattern("he");
    add_req(ACT_SEARCH, 8'h00, 1'b0);
    add_req(ACT_SEARCH, 8'hFF, 1'b1);
    // Longest allowed pattern plus short ones sharing its prefix
    add_pattern("a");
    add_pattern("aa");
    for (int i = 0; i < MAX_DEPTH; i++) add_req(ACT_INSERT, "a", i == MAX_DEPTH - 1);
    for (int i = 0; i < MAX_DEPTH + 2; i++) add_req(ACT_SEARCH, "a", 1'b0);

    // Random: mostly well-formed patterns and texts, some noise
    while (pending_reqs.size() < 160) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add_req(ACT_INSERT, pick_sym(), i == n - 1);
      end else if (r < 85) begin
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++) add_req(ACT_SEARCH, pick_sym(), 1'($urandom_range(0, 1)));
      end else if (r < 92) begin
        add_req(ACT_ROOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        add_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      end
    end

    // Fill the node table with one-symbol patterns over every byte
    for (int b = 0; b < 256; b++) begin
      add_req(ACT_INSERT, 8'(b), 1'b1);
      if (b % 64 == 63) add_text("abca");
    end
    // Fill the pattern table with duplicates of an existing node
    for (int i = 0; i < 50; i++) add_req(ACT_INSERT, "a", 1'b1);
    add_text("aaaaab");
    // Over-long pattern: walks existing nodes, then gets refused for good
    for (int i = 0; i < MAX_DEPTH + 2; i++) add_req(ACT_INSERT, "a", 1'b0);
    add_req(ACT_INSERT, "a", 1'b1);
    add_req(ACT_ROOT, 8'h00, 1'b0);
    add_text("aaaa");

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reqs.size() == 0);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/aho_pkg.sv
hw/rtl/aho_dp.sv
hw/rtl/aho_ctrl.sv
hw/rtl/aho_corasick_matcher.sv
tb/sv/tb.sv
